/* hw/rtl/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and helpers for the signed integer to decimal text unit.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // default width of the signed input value
  localparam int VALUE_BITS_DEF = 16;

  // depth of the queue between classifier and converter
  localparam int QUEUE_DEPTH_DEF = 2;

  // character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // decimal digits needed for a magnitude of up to 2**bits
  function automatic int dec_digits(input int bits);
    return (bits * 301) / 1000 + 1;
  endfunction

endpackage

/* hw/rtl/sitda_front.sv */
// ----------------------------------------------------------------------------
// sitda_front
// Input stage: takes a signed value, splits it into sign and magnitude and
// holds it until the queue has room.
// ----------------------------------------------------------------------------
module sitda_front import sitda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAG_W      = VALUE_BITS + (VALUE_BITS % 2)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [MAG_W:0]        q_entry
);

  logic                  valid_r;
  logic                  valid_nxt;
  logic [MAG_W:0]        entry_r;
  logic                  in_xfer;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;

  // sign and magnitude, the most negative value fits as unsigned
  always_comb begin
    neg = in_value[VALUE_BITS-1];
    mag = neg ? (~in_value + VALUE_BITS'(1)) : in_value;
  end

  // handshake
  assign in_full = valid_r && q_full;
  assign in_xfer = in_push && !in_full;
  assign q_push  = valid_r && !q_full;
  assign q_entry = entry_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      entry_r <= {neg, MAG_W'(mag)};
    end
  end

endmodule

/* hw/rtl/sitda_fifo.sv */
// ----------------------------------------------------------------------------
// sitda_fifo
// Short queue of classified values between front and back ends.
// ----------------------------------------------------------------------------
module sitda_fifo import sitda_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int WIDTH = VALUE_BITS_DEF + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             wr_xfer;
  logic             rd_xfer;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_xfer = push && !full;
  assign rd_xfer = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_xfer) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_xfer) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_xfer && !rd_xfer) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (rd_xfer && !wr_xfer) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_xfer) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hw/rtl/sitda_back.sv */
// ----------------------------------------------------------------------------
// sitda_back
// Converter: shift-and-add-3 binary to BCD, two bits a cycle, then leading
// zero skip and one character per cycle into the output register while it has room.
// ----------------------------------------------------------------------------
module sitda_back import sitda_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAG_W      = VALUE_BITS + (VALUE_BITS % 2)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [MAG_W:0] q_entry,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_char_code,
  output logic           out_last_char
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int BCD_W = 4 * NDIG;
  localparam int ACC_W = BCD_W + MAG_W;
  localparam int STEPS = MAG_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int REM_W = $clog2(NDIG + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             neg_r;
  logic             neg_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] rem_nxt;
  logic             oval_r;
  logic             oval_nxt;
  logic [7:0]       char_r;
  logic [7:0]       char_nxt;
  logic             last_r;
  logic             last_nxt;
  logic             out_xfer;
  logic             slot_free;
  logic             load;
  logic [3:0]       top_dig;
  logic [ACC_W-1:0] dd_two;

  // one shift-and-add-3 step over all digits
  function automatic logic [ACC_W-1:0] dd_step(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] a;
    a = acc;
    for (int d = 0; d < NDIG; d++) begin
      if (a[MAG_W + 4*d +: 4] >= 4'd5) begin
        a[MAG_W + 4*d +: 4] = a[MAG_W + 4*d +: 4] + 4'd3;
      end
    end
    return a << 1;
  endfunction

  assign dd_two  = dd_step(dd_step(acc_r));
  assign top_dig = acc_r[ACC_W-1 -: 4];

  // output register handshake
  assign out_xfer      = out_pop && oval_r;
  assign slot_free     = !oval_r || out_pop;
  assign out_empty     = !oval_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    load      = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          neg_nxt   = q_entry[MAG_W];
          acc_nxt   = {{BCD_W{1'b0}}, q_entry[MAG_W-1:0]};
          cnt_nxt   = CNT_W'(STEPS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        acc_nxt = dd_two;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          rem_nxt   = REM_W'(NDIG);
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // drop leading zeros, always keep the last digit
        if (top_dig == 4'd0 && rem_r != REM_W'(1)) begin
          acc_nxt = acc_r << 4;
          rem_nxt = rem_r - REM_W'(1);
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load      = 1'b1;
          char_nxt  = ASCII_MINUS;
          last_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load     = 1'b1;
          char_nxt = ASCII_ZERO + {4'd0, top_dig};
          last_nxt = (rem_r == REM_W'(1));
          acc_nxt  = acc_r << 4;
          rem_nxt  = rem_r - REM_W'(1);
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    oval_nxt = oval_r;
    if (load) begin
      oval_nxt = 1'b1;
    end else if (out_xfer) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a signed integer to its decimal ASCII text, one character per
// output transfer, with the final character of each run flagged.
// ----------------------------------------------------------------------------
// Each value pushed in comes out as '-' for negatives followed by the digits
// of the magnitude, most significant first, no leading zeros, zero as a
// single '0'; out_last_char marks the end of each run and no NUL follows.
// A front register takes the value and queues its sign and magnitude, so
// further values are taken while the converter works. The converter runs a
// shift-and-add-3 BCD conversion two bits a cycle, then skips leading zeros
// one digit at a time, keeping the last, and emits the sign for a negative
// value and then each digit, each one as the output register has room.
module signed_int_to_decimal_ascii_unit import sitda_pkg::*; #(
  parameter int VALUE_BITS  = VALUE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [7:0]                   out_char_code,
  output logic                         out_last_char
);

  localparam int MAG_W = VALUE_BITS + (VALUE_BITS % 2);

  logic           f_push;
  logic           q_full;
  logic [MAG_W:0] f_entry;
  logic           q_empty;
  logic           q_pop;
  logic [MAG_W:0] q_entry;

  // sign and magnitude split
  sitda_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAG_W      (MAG_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .q_push   (f_push),
    .q_full   (q_full),
    .q_entry  (f_entry)
  );

  // decoupling queue
  sitda_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (MAG_W + 1)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .full  (q_full),
    .wdata (f_entry),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_entry)
  );

  // conversion and character output
  sitda_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAG_W      (MAG_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_entry       (q_entry),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

/* hw/rtl/sitda_checker.sv */
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks for the decimal text unit, bound to the top level.
// ----------------------------------------------------------------------------
module sitda_checker import sitda_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char_code,
  input logic       out_last_char
);

  // only a minus sign or a digit ever leaves the block
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_char_code == ASCII_MINUS) ||
                   ((out_char_code >= ASCII_ZERO) && (out_char_code <= 8'd57)))
    else $error("output character is neither a minus sign nor a digit");

  // a minus sign never ends a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_char_code == ASCII_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as final character");

  // a waiting character holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_char_code) && $stable(out_last_char)))
    else $error("waiting character changed before transfer");

  // reset leaves no output pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  // reset leaves room for input
  a_reset_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_char_code (out_char_code),
  .out_last_char (out_last_char)
);

/* test/signed_int_to_decimal_ascii_unit_tb.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Self-checking bench for the signed integer to decimal text unit: values are
// pushed in bursts, every character popped is compared against a predicted
// text stream, and the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;
  import sitda_pkg::*;

  localparam int VBITS        = VALUE_BITS_DEF;
  localparam int MAX_CHARS    = 12;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  // one predicted output character
  typedef struct packed {
    logic [7:0] code;
    logic       last_char;
  } text_char_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic                    in_full;
  logic signed [VBITS-1:0] in_value = '0;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic [7:0]              out_char_code;
  logic                    out_last_char;

  text_char_t expected_text[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  bit         gaps_on = 1'b1;
  int         burst_left = 0;
  int         holds_requested = 0;
  int         holds_done = 0;
  int         hold_left = 0;
  int         pop_cycle = 0;
  int         pow10[5] = '{1, 10, 100, 1000, 10000};

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VBITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_value     (in_value),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decimal text of one value, queued as expected characters
  function automatic void predict_text(input logic [VBITS-1:0] raw);
    logic [VBITS:0] mag;
    logic           neg;
    logic [3:0]     digs[MAX_CHARS];
    int             nd;
    text_char_t     ch;
    neg = raw[VBITS-1];
    mag = neg ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
    nd  = 0;
    if (mag == '0) begin
      ch.code      = ASCII_ZERO;
      ch.last_char = 1'b1;
      expected_text.push_back(ch);
      return;
    end
    while (mag != '0) begin
      digs[nd] = 4'(mag % 10);
      mag      = mag / 10;
      nd++;
    end
    if (neg) begin
      ch.code      = ASCII_MINUS;
      ch.last_char = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.code      = ASCII_ZERO + 8'(digs[i]);
      ch.last_char = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_push && !in_full) begin
        predict_text(in_value);
      end
      if (out_pop && !out_empty) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character: code %0d last %0b", out_char_code, out_last_char);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            $error("out_char_code mismatch: expected %0d, actual %0d",
                   want.code, out_char_code);
            fail_count++;
          end
          if (out_last_char !== want.last_char) begin
            $error("out_last_char mismatch: expected %0b, actual %0b",
                   want.last_char, out_last_char);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      out_pop   <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_requested) begin
      out_pop    <= 1'b0;
      hold_left  <= LONG_HOLD;
      holds_done <= holds_done + 1;
    end else begin
      pop_cycle <= pop_cycle + 1;
      case (pop_cycle[8:7])
        2'd0: out_pop <= 1'b1;
        2'd1: out_pop <= 1'($urandom_range(0, 1));
        2'd2: out_pop <= 1'(8'b1100_1010 >> pop_cycle[2:0]);
        default: out_pop <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sender idle gap with noise on the value port
  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 12);
    in_push  <= 1'b0;
    in_value <= VBITS'($urandom());
    repeat (n) @(posedge clk);
  endtask

  // offer one value and wait for its transfer
  task automatic send_value(input logic [VBITS-1:0] v);
    in_push  <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_full);
    if (gaps_on) begin
      if (burst_left == 0) begin
        sender_gap();
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // random value, weighted toward digit-count boundaries, extremes and small values
  function automatic logic [VBITS-1:0] pick_value();
    int v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 40) - 20;
      1: begin
        v = pow10[$urandom_range(0, 4)] + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      2: v = $urandom_range(0, 3) == 0 ? -32768 : ($urandom_range(0, 1) ? 32767 : -32767);
      default: v = $urandom();
    endcase
    return VBITS'(v);
  endfunction

  // extremes, every run length, alternating bit patterns
  task automatic test_directed();
    int vals[$] = '{0, 1, -1, 7, -5, 9, 10, -10, 99, 100, 1000, -1001, -9999,
                    10000, -10000, 12345, 21845, -21846, 32767, -32767, -32768};
    foreach (vals[i]) send_value(VBITS'(vals[i]));
  endtask

  // random values in bursts with random gaps
  task automatic test_random_bursts();
    gaps_on = 1'b1;
    repeat (150) send_value(pick_value());
  endtask

  // back-to-back values with no sender gaps
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    repeat (40) send_value(pick_value());
    gaps_on = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, filling the unit
  task automatic test_hold_off();
    gaps_on = 1'b0;
    holds_requested <= holds_requested + 1;
    repeat (30) send_value(pick_value());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_bursts();
    test_back_to_back();
    test_hold_off();
    in_push <= 1'b0;
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_front.sv
hw/rtl/sitda_fifo.sv
hw/rtl/sitda_back.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
hw/rtl/sitda_checker.sv
test/signed_int_to_decimal_ascii_unit_tb.sv
